// ===== hdl/gbts_pkg.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text store package
// Request and status codes and the field widths of the request and result
// transactions.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT     = 3'd0,
    REQ_DEL_BEFORE = 3'd1,
    REQ_DEL_AFTER  = 3'd2,
    REQ_MOVE       = 3'd3,
    REQ_READ       = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

// ===== hdl/gbts_ram.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text store RAM
// Simple dual-port synchronous RAM with one write port and one read port.
// Read data is registered and holds while no read is enabled.
// ----------------------------------------------------------------------------
module gbts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/gap_buffer_text_store_core.sv =====
// ----------------------------------------------------------------------------
// Gap buffer text store core
// Fixed-capacity gap buffer for editor text. Serves insert, backspace,
// delete, cursor move and read requests and returns one result per request.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i, in_stall_o  req_type_i, data_in_i, position_i
// result    out        out_valid_o, out_stall_i status_o, read_byte_o,
//                                              text_length_o, cursor_pos_o
//
// Insert, deletes, refused requests and unused codes are answered straight from
// the idle state. A read passes through a read state for the registered RAM read.
// A cursor move alternates move and write states: each byte moved is one RAM read
// followed by one RAM write through the single read and write port pair.
// Reset clears the gap pointers, state and output valid; the text RAM needs no clearing pass.
// A result waits in the output register while out_stall_i is high, and a new
// request is taken in the idle state once that register is free or being emptied.
module gap_buffer_text_store_core #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gbts_pkg::REQ_W-1:0]     req_type_i,
  input  logic [gbts_pkg::BYTE_W-1:0]    data_in_i,
  input  logic [gbts_pkg::POS_W-1:0]     position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gbts_pkg::STATUS_W-1:0]  status_o,
  output logic [gbts_pkg::BYTE_W-1:0]    read_byte_o,
  output logic [gbts_pkg::POS_W-1:0]     text_length_o,
  output logic [gbts_pkg::POS_W-1:0]     cursor_pos_o
);

  import gbts_pkg::*;

  localparam int unsigned PW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CMPW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] CAP_V = PW'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_MOVE  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [PW-1:0]       head_q, head_d;
  logic [PW-1:0]       tail_q, tail_d;
  logic [PW-1:0]       target_q, target_d;
  logic [AW-1:0]       mvaddr_q, mvaddr_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [BYTE_W-1:0]   rbyte_q, rbyte_d;
  logic [PW-1:0]       olen_q, olen_d;
  logic [PW-1:0]       ocur_q, ocur_d;

  logic                accept;
  logic                emit;
  logic [PW-1:0]       len;
  logic [CMPW-1:0]     pos_ext;
  logic [CMPW-1:0]     len_ext;
  logic [PW-1:0]       pos_pw;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  assign len     = CAP_V - (tail_q - head_q);
  assign pos_ext = CMPW'(position_i);
  assign len_ext = CMPW'(len);
  assign pos_pw  = PW'(position_i);

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    target_d  = target_q;
    mvaddr_d  = mvaddr_q;
    emit      = 1'b0;
    status_d  = ST_OK;
    rbyte_d   = '0;
    ram_we    = 1'b0;
    ram_waddr = AW'(head_q);
    ram_wdata = data_in_i;
    ram_re    = 1'b0;
    ram_raddr = AW'(head_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_INSERT: begin
              emit = 1'b1;
              if (head_q >= tail_q) begin
                status_d = ST_FULL;
              end else begin
                ram_we = 1'b1;
                head_d = head_q + 1'b1;
              end
            end
            REQ_DEL_BEFORE: begin
              emit = 1'b1;
              if (head_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                head_d = head_q - 1'b1;
              end
            end
            REQ_DEL_AFTER: begin
              emit = 1'b1;
              if (tail_q >= CAP_V) begin
                status_d = ST_EMPTY;
              end else begin
                tail_d = tail_q + 1'b1;
              end
            end
            REQ_MOVE: begin
              if (pos_ext > len_ext) begin
                emit     = 1'b1;
                status_d = ST_RANGE;
              end else begin
                target_d = pos_pw;
                state_d  = S_MOVE;
              end
            end
            REQ_READ: begin
              if (pos_ext >= len_ext) begin
                emit     = 1'b1;
                status_d = ST_RANGE;
              end else begin
                ram_re = 1'b1;
                if (pos_pw < head_q) begin
                  ram_raddr = AW'(pos_pw);
                end else begin
                  ram_raddr = AW'(tail_q + (pos_pw - head_q));
                end
                state_d = S_READ;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        emit    = 1'b1;
        rbyte_d = ram_rdata;
        state_d = S_IDLE;
      end
      S_MOVE: begin
        if (head_q == target_q) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end else if (head_q > target_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(head_q - 1'b1);
          mvaddr_d  = AW'(tail_q - 1'b1);
          head_d    = head_q - 1'b1;
          tail_d    = tail_q - 1'b1;
          state_d   = S_WRITE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(tail_q);
          mvaddr_d  = AW'(head_q);
          head_d    = head_q + 1'b1;
          tail_d    = tail_q + 1'b1;
          state_d   = S_WRITE;
        end
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = mvaddr_q;
        ram_wdata = ram_rdata;
        state_d   = S_MOVE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    olen_d = CAP_V - (tail_d - head_d);
    ocur_d = head_d;
    out_valid_d = (out_valid_q && out_stall_i) || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= CAP_V;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    mvaddr_q <= mvaddr_d;
    if (emit) begin
      status_q <= status_d;
      rbyte_q  <= rbyte_d;
      olen_q   <= olen_d;
      ocur_q   <= ocur_d;
    end
  end

  gbts_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CAPACITY)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_byte_o   = rbyte_q;
  assign text_length_o = POS_W'(olen_q);
  assign cursor_pos_o  = POS_W'(ocur_q);

  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= tail_q) && (tail_q <= CAP_V))
    else $error("Gap pointers out of order.");

  a_single_cycle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i != REQ_MOVE) && (req_type_i != REQ_READ)) |=> out_valid_q)
    else $error("Single-cycle transaction gave no result.");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == REQ_READ) && (pos_ext < len_ext)) |=> ##1 out_valid_q)
    else $error("Read transaction gave no result after two cycles.");

  a_gap_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(tail_q - head_q))
    else $error("Gap size changed during a read or cursor move.");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_valid_q) |-> !out_stall_i)
    else $error("Result overwrote a stalled result.");

endmodule

// ===== verif/gap_buffer_text_store_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer text store checker
// Watches the request and result channels of the gap buffer core. It keeps
// its own copy of the text store and the gap pointers, works out the result
// of every accepted request, and compares each accepted result field by field
// with the oldest expected one. It reports the number of failures and the
// number of results still owed.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_checker #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  logic                           req_stall_i,
  input  logic [gbts_pkg::REQ_W-1:0]     req_type_i,
  input  logic [gbts_pkg::BYTE_W-1:0]    data_in_i,
  input  logic [gbts_pkg::POS_W-1:0]     position_i,
  input  logic                           res_valid_i,
  input  logic                           res_stall_i,
  input  logic [gbts_pkg::STATUS_W-1:0]  status_i,
  input  logic [gbts_pkg::BYTE_W-1:0]    read_byte_i,
  input  logic [gbts_pkg::POS_W-1:0]     text_length_i,
  input  logic [gbts_pkg::POS_W-1:0]     cursor_pos_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);

  import gbts_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   read_byte;
    logic [POS_W-1:0]    text_length;
    logic [POS_W-1:0]    cursor_pos;
  } edit_result_t;

  logic [BYTE_W-1:0] text_copy [CAPACITY];
  int unsigned       head_ptr;
  int unsigned       gap_end;
  int unsigned       fail_total;
  edit_result_t      expected_results [$];

  function automatic edit_result_t apply_edit(input logic [REQ_W-1:0] kind,
                                              input logic [BYTE_W-1:0] byte_val,
                                              input logic [POS_W-1:0] pos);
    edit_result_t res;
    int unsigned  len;
    int unsigned  target;
    res.status    = ST_OK;
    res.read_byte = '0;
    len           = CAPACITY - (gap_end - head_ptr);
    target        = pos;
    case (kind)
      REQ_INSERT: begin
        if (head_ptr >= gap_end) begin
          res.status = ST_FULL;
        end else begin
          text_copy[head_ptr] = byte_val;
          head_ptr++;
        end
      end
      REQ_DEL_BEFORE: begin
        if (head_ptr == 0) res.status = ST_EMPTY;
        else head_ptr--;
      end
      REQ_DEL_AFTER: begin
        if (gap_end >= CAPACITY) res.status = ST_EMPTY;
        else gap_end++;
      end
      REQ_MOVE: begin
        if (target > len) begin
          res.status = ST_RANGE;
        end else begin
          while (head_ptr > target) begin
            head_ptr--;
            gap_end--;
            text_copy[gap_end] = text_copy[head_ptr];
          end
          while (head_ptr < target) begin
            text_copy[head_ptr] = text_copy[gap_end];
            head_ptr++;
            gap_end++;
          end
        end
      end
      REQ_READ: begin
        if (target >= len) res.status = ST_RANGE;
        else if (target < head_ptr) res.read_byte = text_copy[target];
        else res.read_byte = text_copy[gap_end + (target - head_ptr)];
      end
      default: ;
    endcase
    res.text_length = POS_W'(CAPACITY - (gap_end - head_ptr));
    res.cursor_pos  = POS_W'(head_ptr);
    return res;
  endfunction

  function automatic bit field_ok(input string name, input int unsigned want,
                                  input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    edit_result_t want;
    bit           ok;
    if (!rst_ni) begin
      head_ptr = 0;
      gap_end   = CAPACITY;
      fail_total = 0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result transaction with none expected, status %0d length %0d",
                   $time, status_i, text_length_i);
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          ok = 1'b1;
          ok &= field_ok("status", want.status, status_i);
          ok &= field_ok("read_byte", want.read_byte, read_byte_i);
          ok &= field_ok("text_length", want.text_length, text_length_i);
          ok &= field_ok("cursor_pos", want.cursor_pos, cursor_pos_i);
          if (!ok) fail_total++;
        end
      end
      if (req_valid_i && !req_stall_i) begin
        expected_results.push_back(apply_edit(req_type_i, data_in_i, position_i));
      end
      fail_count_o <= fail_total;
      pending_o    <= expected_results.size();
    end
  end

endmodule

// ===== verif/gap_buffer_text_store_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer text store core testbench
// Drives edit and read requests into the gap buffer core: a directed opening
// on the empty and nearly empty buffer, then random editing on short texts
// under several idle patterns. The checker beside the core predicts and
// compares.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_core_test;

  import gbts_pkg::*;

  localparam int unsigned CAPACITY    = 4096;
  localparam int unsigned SETTLE_CYC  = 32;
  localparam int unsigned RANDOM_RUN  = 500;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  req_type    = '0;
  logic [BYTE_W-1:0] data_in     = '0;
  logic [POS_W-1:0]  position    = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0] read_byte;
  logic [POS_W-1:0]  text_length;
  logic [POS_W-1:0]  cursor_pos;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned text_len      = 0;
  int unsigned cursor        = 0;

  always #5 clk = ~clk;

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  gap_buffer_text_store_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .data_in_i     (data_in),
    .position_i    (position),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .read_byte_o   (read_byte),
    .text_length_o (text_length),
    .cursor_pos_o  (cursor_pos)
  );

  gap_buffer_text_store_checker #(
    .CAPACITY(CAPACITY)
  ) edit_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (in_valid),
    .req_stall_i   (in_stall),
    .req_type_i    (req_type),
    .data_in_i     (data_in),
    .position_i    (position),
    .res_valid_i   (out_valid),
    .res_stall_i   (out_stall),
    .status_i      (status),
    .read_byte_i   (read_byte),
    .text_length_i (text_length),
    .cursor_pos_i  (cursor_pos),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [BYTE_W-1:0] byte_val,
                              input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    data_in  <= byte_val;
    position <= pos;
    do @(posedge clk); while (in_stall);
    case (kind)
      REQ_INSERT:     if (text_len < CAPACITY) begin text_len++; cursor++; end
      REQ_DEL_BEFORE: if (cursor > 0) begin text_len--; cursor--; end
      REQ_DEL_AFTER:  if (cursor < text_len) text_len--;
      REQ_MOVE:       if (pos <= text_len) cursor = pos;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Short texts keep cursor moves cheap; a few requests are pure noise.
  task automatic send_random();
    int unsigned       pick;
    int unsigned       ins_share;
    logic [BYTE_W-1:0] b;
    logic [POS_W-1:0]  p;
    b         = BYTE_W'($urandom_range(255));
    p         = POS_W'($urandom_range(8191));
    ins_share = (text_len > 48) ? 10 : 35;
    pick      = $urandom_range(99);
    if (pick < 5) begin
      send_request(REQ_W'($urandom_range(7)), b, p);
    end else begin
      pick = $urandom_range(99);
      if (pick < ins_share) send_request(REQ_INSERT, b, p);
      else if (pick < ins_share + 15) send_request(REQ_DEL_BEFORE, b, p);
      else if (pick < ins_share + 30) send_request(REQ_DEL_AFTER, b, p);
      else if (pick < ins_share + 50)
        send_request(REQ_MOVE, b, POS_W'($urandom_range(text_len + 1)));
      else send_request(REQ_READ, b, POS_W'($urandom_range(text_len)));
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 30;
    recv_idle_pct = 49;

    // Empty buffer: both deletes refused, read refused, move to zero allowed.
    send_request(REQ_DEL_BEFORE, '0, '0);
    send_request(REQ_DEL_AFTER, '1, '1);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_MOVE, '0, '0);
    send_request(REQ_MOVE, '0, POS_W'(1));
    send_request(REQ_INSERT, '0, '0);
    send_request(REQ_INSERT, '1, '1);
    send_request(REQ_INSERT, 8'hA5, '0);
    send_request(REQ_READ, '0, '0);
    send_request(REQ_READ, '0, POS_W'(2));
    send_request(REQ_READ, '0, POS_W'(3));
    send_request(REQ_MOVE, '0, '0);
    send_request(REQ_MOVE, '0, POS_W'(3));
    send_request(REQ_MOVE, '0, POS_W'(1));
    send_request(REQ_MOVE, '0, POS_W'(1));
    send_request(REQ_DEL_AFTER, '0, '0);
    send_request(REQ_DEL_BEFORE, '0, '0);
    send_request(REQ_READ, '0, '1);
    send_request(REQ_MOVE, '0, '1);
    send_request(REQ_MOVE, '0, POS_W'(CAPACITY));
    for (int c = int'(REQ_READ) + 1; c < 2 ** REQ_W; c++) begin
      send_request(REQ_W'(c), '1, '1);
    end

    repeat (RANDOM_RUN) send_random();

    in_valid <= 1'b0;
    wait_drained();
    @(negedge clk);

    send_idle_pct = 49;
    recv_idle_pct = 30;
    repeat (RANDOM_RUN) send_random();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_RUN) send_random();

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
